// File: design/abd_pkg.sv
// Shared types and constants of the auto baud detector.
`default_nettype none
package abd_pkg;

  localparam int MaxEdges  = 20;
  localparam int TimeW     = 63;
  localparam int GapW      = 31;
  localparam int PeriodW   = 20;
  localparam int MinEdgeW  = 6;
  localparam int TimeoutW  = 32;
  localparam int EdgesOutW = 6;
  localparam int EdgeCntW  = $clog2(MaxEdges + 1);
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;
  localparam int InDataW   = 64;
  localparam int OutDataW  = 40;

  localparam logic [PeriodW-1:0]  FirstPeriodRst  = PeriodW'(104);
  localparam logic [PeriodW-1:0]  SecondPeriodRst = PeriodW'(8);
  localparam logic [MinEdgeW-1:0] MinEdgesRst     = MinEdgeW'(10);
  localparam logic [TimeoutW-1:0] TimeoutRst      = TimeoutW'(5000000);
  localparam logic [GapW-1:0]     GapMax          = {GapW{1'b1}};
  localparam logic [EdgeCntW-1:0] EdgeLimit       = EdgeCntW'(MaxEdges);

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_EDGE  = 2'd1,
    KIND_CHECK = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RATE_UNKNOWN = 2'd0,
    RATE_FIRST   = 2'd1,
    RATE_SECOND  = 2'd2
  } rate_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FIRST_PERIOD  = 2'd0,
    REG_SECOND_PERIOD = 2'd1,
    REG_MIN_EDGES     = 2'd2,
    REG_TIMEOUT       = 2'd3
  } cfg_reg_t;

endpackage
`default_nettype wire

// File: design/auto_baud_detector.sv
// A request is registered on entry; the result of a finishing request is registered and shown on out_.
// Throughput: one request per cycle while out_ is not stalled; the state update (63-bit subtract,
// saturate, min compare) sits between the input register and the result register.
// A full result register with out_tready low holds the input register; in_tready drops once both are full.
// Reset (synchronous, rst_n low): detector idle, registers at their documented defaults,
// both pipeline stages empty.
`default_nettype none
module auto_baud_detector (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [abd_pkg::InDataW-1:0]   in_tdata,   // [62:0] time_us, [63] zero
  input  wire logic [1:0]                    in_tuser,   // [1:0] kind
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [abd_pkg::OutDataW-1:0]       out_tdata,  // [0] found, [2:1] rate_choice,
                                                         // [8:3] edges_seen,
                                                         // [39:9] smallest_gap_us
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [abd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [abd_pkg::CfgDataW-1:0]  cfg_data
);

  // configuration
  logic [abd_pkg::PeriodW-1:0]  first_period_r;
  logic [abd_pkg::PeriodW-1:0]  second_period_r;
  logic [abd_pkg::MinEdgeW-1:0] min_edges_r;
  logic [abd_pkg::TimeoutW-1:0] timeout_r;

  // input register
  logic                         s_valid_r;
  abd_pkg::kind_t               s_kind_r;
  logic [abd_pkg::TimeW-1:0]    s_time_r;

  // detector state
  logic                         running_r, running_nxt;
  logic [abd_pkg::TimeW-1:0]    start_time_r, start_time_nxt;
  logic [abd_pkg::TimeW-1:0]    last_time_r, last_time_nxt;
  logic [abd_pkg::EdgeCntW-1:0] edge_cnt_r, edge_cnt_nxt;
  logic [abd_pkg::GapW-1:0]     min_gap_r, min_gap_nxt;

  // result register
  logic                         out_valid_r;
  logic                         found_r, found_nxt;
  abd_pkg::rate_t               rate_r, rate_nxt;
  logic [abd_pkg::EdgesOutW-1:0] edges_r, edges_nxt;
  logic [abd_pkg::GapW-1:0]     gap_out_r, gap_out_nxt;

  logic                         adv;
  logic                         s_fire;
  logic                         emit;
  logic [abd_pkg::TimeW-1:0]    elapsed;
  logic [abd_pkg::TimeW-1:0]    gap_raw;
  logic [abd_pkg::GapW-1:0]     gap_sat;
  logic                         expired;
  logic [abd_pkg::GapW-1:0]     fin_gap;
  logic [abd_pkg::EdgeCntW-1:0] fin_cnt;
  logic [abd_pkg::GapW-1:0]     d1, d2;
  logic [abd_pkg::GapW-1:0]     p1, p2;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s_valid_r || adv;
  assign s_fire    = s_valid_r && adv;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {gap_out_r, edges_r, rate_r, found_r};

  assign elapsed = s_time_r - start_time_r;
  assign gap_raw = s_time_r - last_time_r;
  assign gap_sat = (|gap_raw[abd_pkg::TimeW-1:abd_pkg::GapW]) ? abd_pkg::GapMax
                                                               : gap_raw[abd_pkg::GapW-1:0];
  assign expired = (|elapsed[abd_pkg::TimeW-1:abd_pkg::TimeoutW]) ||
                   (elapsed[abd_pkg::TimeoutW-1:0] >= timeout_r);

  assign p1 = abd_pkg::GapW'(first_period_r);
  assign p2 = abd_pkg::GapW'(second_period_r);

  always_comb begin
    running_nxt    = running_r;
    start_time_nxt = start_time_r;
    last_time_nxt  = last_time_r;
    edge_cnt_nxt   = edge_cnt_r;
    min_gap_nxt    = min_gap_r;
    emit           = 1'b0;
    fin_gap        = min_gap_r;
    fin_cnt        = edge_cnt_r;
    case (s_kind_r)
      abd_pkg::KIND_START: begin
        running_nxt    = 1'b1;
        start_time_nxt = s_time_r;
        last_time_nxt  = s_time_r;
        edge_cnt_nxt   = '0;
        min_gap_nxt    = abd_pkg::GapMax;
      end
      abd_pkg::KIND_EDGE, abd_pkg::KIND_CHECK: begin
        if (running_r) begin
          if (expired) begin
            emit        = 1'b1;
            running_nxt = 1'b0;
          end else if (s_kind_r == abd_pkg::KIND_EDGE) begin
            last_time_nxt = s_time_r;
            edge_cnt_nxt  = edge_cnt_r + abd_pkg::EdgeCntW'(1);
            if (gap_sat < min_gap_r) min_gap_nxt = gap_sat;
            fin_gap = min_gap_nxt;
            fin_cnt = edge_cnt_nxt;
            if (edge_cnt_nxt >= abd_pkg::EdgeLimit) begin
              emit        = 1'b1;
              running_nxt = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    d1 = (fin_gap >= p1) ? fin_gap - p1 : p1 - fin_gap;
    d2 = (fin_gap >= p2) ? fin_gap - p2 : p2 - fin_gap;
    found_nxt   = abd_pkg::EdgesOutW'(fin_cnt) > min_edges_r;
    rate_nxt    = abd_pkg::RATE_UNKNOWN;
    if (found_nxt) rate_nxt = (d2 < d1) ? abd_pkg::RATE_SECOND : abd_pkg::RATE_FIRST;
    edges_nxt   = abd_pkg::EdgesOutW'(fin_cnt);
    gap_out_nxt = fin_gap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_period_r  <= abd_pkg::FirstPeriodRst;
      second_period_r <= abd_pkg::SecondPeriodRst;
      min_edges_r     <= abd_pkg::MinEdgesRst;
      timeout_r       <= abd_pkg::TimeoutRst;
    end else if (cfg_valid && cfg_ready) begin
      case (abd_pkg::cfg_reg_t'(cfg_index))
        abd_pkg::REG_FIRST_PERIOD:  first_period_r  <= cfg_data[abd_pkg::PeriodW-1:0];
        abd_pkg::REG_SECOND_PERIOD: second_period_r <= cfg_data[abd_pkg::PeriodW-1:0];
        abd_pkg::REG_MIN_EDGES:     min_edges_r     <= cfg_data[abd_pkg::MinEdgeW-1:0];
        abd_pkg::REG_TIMEOUT:       timeout_r       <= cfg_data[abd_pkg::TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r    <= 1'b0;
      running_r    <= 1'b0;
      start_time_r <= '0;
      last_time_r  <= '0;
      edge_cnt_r   <= '0;
      min_gap_r    <= abd_pkg::GapMax;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s_valid_r <= 1'b1;
        s_kind_r  <= abd_pkg::kind_t'(in_tuser);
        s_time_r  <= in_tdata[abd_pkg::TimeW-1:0];
      end else if (s_fire) begin
        s_valid_r <= 1'b0;
      end
      if (s_fire) begin
        running_r    <= running_nxt;
        start_time_r <= start_time_nxt;
        last_time_r  <= last_time_nxt;
        edge_cnt_r   <= edge_cnt_nxt;
        min_gap_r    <= min_gap_nxt;
      end
      if (s_fire && emit) begin
        out_valid_r <= 1'b1;
        found_r     <= found_nxt;
        rate_r      <= rate_nxt;
        edges_r     <= edges_nxt;
        gap_out_r   <= gap_out_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // a finishing request always lands in the result register and closes the window
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s_fire && emit) |=> (out_valid_r && !running_r))
    else $error("finished detection did not produce a result");

  // the edge counter never sits at the limit while a window is open
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (edge_cnt_r < abd_pkg::EdgeLimit))
    else $error("edge count reached limit without finishing");

  // a result without enough edges carries no rate
  a_unknown_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !found_r) |-> (rate_r == abd_pkg::RATE_UNKNOWN))
    else $error("rate chosen without detection");

  // the input register only drains when the result slot can take a request
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && s_valid_r) |=> s_valid_r)
    else $error("input register drained while result stalled");

endmodule
`default_nettype wire
